/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the LCD write sequencer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

/* design/clwseq_pkg.sv */
// ----------------------------------------------------------------------------
// clwseq_pkg
// Types, codes, hold times and the initialisation script of the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package clwseq_pkg;

	localparam int MAX_DIGITS_DEF = 5;
	localparam int DCNT_W = 3;
	localparam int UNIT_W = 4;
	localparam int PH_W = 3;
	localparam int HOLD_W = 18;

	localparam logic [UNIT_W-1:0] INIT_LAST_UNIT = 4'd11;
	localparam logic [UNIT_W-1:0] CLEAR_LAST_UNIT = 4'd1;

	localparam logic [PH_W-1:0] PH_HI_HIGH = 3'd0;
	localparam logic [PH_W-1:0] PH_HI_LOW = 3'd1;
	localparam logic [PH_W-1:0] PH_LO_HIGH = 3'd2;
	localparam logic [PH_W-1:0] PH_LO_LOW = 3'd3;
	localparam logic [PH_W-1:0] PH_SETTLE = 3'd4;

	localparam logic [HOLD_W-1:0] STROBE_US = 18'd1;
	localparam logic [HOLD_W-1:0] POWER_WAIT_US = 18'd250000;
	localparam logic [HOLD_W-1:0] INIT_WAIT1_US = 18'd7000;
	localparam logic [HOLD_W-1:0] INIT_WAIT2_US = 18'd150;
	localparam logic [HOLD_W-1:0] INIT_WAIT3_US = 18'd100;
	localparam logic [HOLD_W-1:0] INIT_WAIT4_US = 18'd150;

	localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
	localparam logic [7:0] CMD_DISPLAY_OFF = 8'h08;
	localparam logic [7:0] CMD_CLEAR = 8'h01;
	localparam logic [7:0] CMD_HOME = 8'h02;
	localparam logic [7:0] CMD_HOME_ALT = 8'h03;
	localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
	localparam logic [7:0] CMD_DISPLAY_ON = 8'h0F;
	localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
	localparam logic [7:0] NIB_WAKE = 8'h03;
	localparam logic [7:0] NIB_FOUR_BIT = 8'h02;
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] LINE0_LAST = 8'h1F;
	localparam logic [7:0] LINE1_FIRST = 8'h40;
	localparam logic [7:0] LINE1_LAST = 8'h5F;

	localparam logic REG_SETTLE = 1'b0;
	localparam logic REG_CLEAR = 1'b1;

	typedef enum logic [2:0] {
		REQ_INIT = 3'd0,
		REQ_CMD = 3'd1,
		REQ_DATA = 3'd2,
		REQ_POS = 3'd3,
		REQ_CLEAR = 3'd4,
		REQ_NUM = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		UK_IDLE = 2'd0,
		UK_NIBBLE = 2'd1,
		UK_BYTE = 2'd2
	} unit_kind_t;

	typedef enum logic [2:0] {
		HOLD_POWER = 3'd0,
		HOLD_WAIT1 = 3'd1,
		HOLD_WAIT2 = 3'd2,
		HOLD_WAIT3 = 3'd3,
		HOLD_WAIT4 = 3'd4,
		HOLD_SETTLE = 3'd5,
		HOLD_CLEAR = 3'd6
	} hold_sel_t;

	typedef struct packed {
		unit_kind_t kind;
		logic [7:0] value;
		hold_sel_t hold;
	} unit_t;

	typedef struct packed {
		logic load;
		logic pop;
		logic [15:0] value;
		logic [DCNT_W-1:0] count;
	} dig_ctrl_t;

	typedef struct packed {
		logic busy;
		logic [3:0] top;
	} dig_stat_t;

	function automatic unit_t init_unit(input logic [UNIT_W-1:0] idx);
		unit_t u;
		u.kind = UK_BYTE;
		u.value = 8'h00;
		u.hold = HOLD_SETTLE;
		case (idx)
			4'd0: begin
				u.kind = UK_IDLE;
				u.hold = HOLD_POWER;
			end
			4'd1: begin
				u.kind = UK_NIBBLE;
				u.value = NIB_WAKE;
				u.hold = HOLD_WAIT1;
			end
			4'd2: begin
				u.kind = UK_NIBBLE;
				u.value = NIB_WAKE;
				u.hold = HOLD_WAIT2;
			end
			4'd3: begin
				u.kind = UK_NIBBLE;
				u.value = NIB_WAKE;
				u.hold = HOLD_WAIT3;
			end
			4'd4: begin
				u.kind = UK_NIBBLE;
				u.value = NIB_FOUR_BIT;
				u.hold = HOLD_WAIT4;
			end
			4'd5: u.value = CMD_FUNCTION_SET;
			4'd6: u.value = CMD_DISPLAY_OFF;
			4'd7: begin
				u.value = CMD_CLEAR;
				u.hold = HOLD_CLEAR;
			end
			4'd8: u.value = CMD_ENTRY_MODE;
			4'd9: u.value = CMD_DISPLAY_ON;
			4'd10: begin
				u.value = CMD_CLEAR;
				u.hold = HOLD_CLEAR;
			end
			4'd11: begin
				u.value = CMD_HOME;
				u.hold = HOLD_CLEAR;
			end
			default: begin
				u.kind = UK_IDLE;
				u.hold = HOLD_POWER;
			end
		endcase
		return u;
	endfunction

	function automatic logic [PH_W-1:0] start_phase(input unit_kind_t kind);
		logic [PH_W-1:0] ph;
		unique case (kind)
			UK_IDLE: ph = PH_SETTLE;
			UK_NIBBLE: ph = PH_LO_HIGH;
			default: ph = PH_HI_HIGH;
		endcase
		return ph;
	endfunction

endpackage

/* design/clwseq_digits.sv */
// ----------------------------------------------------------------------------
// clwseq_digits
// Decimal digit extractor: each divide-by-ten step registers the quotient,
// then stacks the remainder so that the most significant comes out first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clwseq_digits #(
	parameter int MAX_DIGITS = clwseq_pkg::MAX_DIGITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input clwseq_pkg::dig_ctrl_t ctrl,
	output clwseq_pkg::dig_stat_t stat
);
	import clwseq_pkg::*;

	localparam logic [15:0] RECIP_TEN = 16'd52429;

	logic run_q;
	logic half_q;
	logic [DCNT_W-1:0] dleft_q;
	logic [15:0] x_q;
	logic [12:0] quo_q;
	logic [3:0] stk_q [MAX_DIGITS];

	logic [31:0] prod;
	logic [15:0] ten_quo;
	logic [15:0] rem;

	assign prod = x_q * RECIP_TEN;
	assign ten_quo = {quo_q, 3'b000} + {2'b00, quo_q, 1'b0};
	assign rem = x_q - ten_quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			half_q <= 1'b0;
			dleft_q <= '0;
		end else if (ctrl.load) begin
			run_q <= 1'b1;
			half_q <= 1'b0;
			dleft_q <= ctrl.count;
		end else if (run_q) begin
			half_q <= !half_q;
			if (half_q) begin
				dleft_q <= dleft_q - 1'b1;
				if (dleft_q == DCNT_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_q <= ctrl.value;
		end else if (run_q && !half_q) begin
			quo_q <= prod[31:19];
		end else if (run_q && half_q) begin
			x_q <= {3'b000, quo_q};
			stk_q[0] <= rem[3:0];
			for (int i = 1; i < MAX_DIGITS; i++) begin
				stk_q[i] <= stk_q[i-1];
			end
		end else if (ctrl.pop) begin
			for (int i = 0; i < MAX_DIGITS - 1; i++) begin
				stk_q[i] <= stk_q[i+1];
			end
			stk_q[MAX_DIGITS-1] <= 4'd0;
		end
	end

	assign stat.busy = run_q;
	assign stat.top = stk_q[0];

	`ASSERT_NEVER(a_pop_while_busy, clk, arst_n, ctrl.pop && run_q, "digit pop during extraction")
	`ASSERT_HOLDS(a_load_starts, clk, arst_n, ctrl.load && (ctrl.count != '0) |=> run_q, "load did not start extraction")
	`ASSERT_HOLDS(a_finish_count, clk, arst_n, $fell(run_q) |-> (dleft_q == '0), "extraction ended with digits left")
	`ASSERT_HOLDS(a_digit_range, clk, arst_n, run_q && half_q |-> (rem < 16'd10), "remainder out of decimal range")

endmodule

/* design/char_lcd_4bit_write_sequencer.sv */
// The first pin state follows in the cycle after a request is taken, or, after a
// decimal number request, once its digits have been found.
// Throughput: one pin state per cycle; busy stays high until the last state is shown,
// so an initialisation request shows all of its 48 states before the next is taken.
// Results are strobed for one cycle each; the receiver cannot stall them.
// Reset is asynchronous: idle, settle time 60 us and clear time 3000 us.
// ----------------------------------------------------------------------------
// char_lcd_4bit_write_sequencer
// Turns display requests into timed pin states for a character LCD on a
// 4-bit bus, with a register port for the settle and clear hold times.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module char_lcd_4bit_write_sequencer #(
	parameter int MAX_DIGITS = clwseq_pkg::MAX_DIGITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [2:0] req_type,
	input logic [7:0] byte_value,
	input logic [7:0] ddram_address,
	input logic line_select,
	input logic [15:0] number_value,
	input logic [2:0] digit_count,
	output logic strobe,
	output logic [3:0] data_nibble,
	output logic enable_pin,
	output logic register_select,
	output logic [clwseq_pkg::HOLD_W-1:0] hold_us,
	output logic last_state,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import clwseq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIGITS = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t state_q;
	req_t req_q;
	logic [7:0] byte_q;
	logic [UNIT_W-1:0] unit_q;
	logic [UNIT_W-1:0] ulast_q;
	logic [PH_W-1:0] ph_q;
	logic [9:0] settle_q;
	logic [15:0] clear_q;

	dig_ctrl_t dig_ctrl;
	dig_stat_t dig_stat;

	logic accept;
	logic cfg_wr;
	logic [DCNT_W-1:0] cnt;
	logic pos_ok;
	logic unit_end;
	logic req_end;
	unit_t cur;
	logic cur_rs;
	unit_t next_init;
	logic [UNIT_W-1:0] unit_nx;

	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE);
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CLEAR) ? {16'd0, clear_q} : {22'd0, settle_q};

	always_comb begin
		if (int'(digit_count) > MAX_DIGITS) begin
			cnt = DCNT_W'(MAX_DIGITS);
		end else begin
			cnt = digit_count;
		end
	end

	assign pos_ok = (!line_select && ddram_address <= LINE0_LAST) ||
		(line_select && ddram_address >= LINE1_FIRST && ddram_address <= LINE1_LAST);

	always_comb begin
		cur = '{kind: UK_BYTE, value: byte_q, hold: HOLD_SETTLE};
		cur_rs = 1'b0;
		case (req_q)
			REQ_INIT: cur = init_unit(unit_q);
			REQ_CMD: begin
				if (byte_q == CMD_CLEAR || byte_q == CMD_HOME || byte_q == CMD_HOME_ALT) begin
					cur.hold = HOLD_CLEAR;
				end
			end
			REQ_DATA: cur_rs = 1'b1;
			REQ_CLEAR: begin
				cur.value = (unit_q == '0) ? CMD_CLEAR : CMD_HOME;
				cur.hold = HOLD_CLEAR;
			end
			REQ_NUM: begin
				cur.value = ASCII_ZERO + {4'd0, dig_stat.top};
				cur_rs = 1'b1;
			end
			default: ;
		endcase
	end

	assign unit_nx = unit_q + 1'b1;
	assign next_init = init_unit(unit_nx);
	assign unit_end = (ph_q == PH_SETTLE);
	assign req_end = unit_end && (unit_q == ulast_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			settle_q <= 10'd60;
			clear_q <= 16'd3000;
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == REG_SETTLE) begin
					settle_q <= pwdata[9:0];
				end else begin
					clear_q <= pwdata[15:0];
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req_type)
							REQ_INIT, REQ_CMD, REQ_DATA, REQ_CLEAR: state_q <= ST_EMIT;
							REQ_POS: if (pos_ok) state_q <= ST_EMIT;
							REQ_NUM: if (cnt != '0) state_q <= ST_DIGITS;
							default: ;
						endcase
					end
				end
				ST_DIGITS: begin
					if (!dig_stat.busy) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (req_end) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			req_q <= req_t'(req_type);
			unit_q <= '0;
			ph_q <= (req_type == REQ_INIT) ? PH_SETTLE : PH_HI_HIGH;
			byte_q <= (req_type == REQ_POS) ? (ddram_address | CMD_SET_DDRAM) : byte_value;
			case (req_type)
				REQ_INIT: ulast_q <= INIT_LAST_UNIT;
				REQ_CLEAR: ulast_q <= CLEAR_LAST_UNIT;
				REQ_NUM: ulast_q <= UNIT_W'(cnt) - 1'b1;
				default: ulast_q <= '0;
			endcase
		end else if (state_q == ST_EMIT) begin
			if (unit_end) begin
				unit_q <= unit_nx;
				ph_q <= (req_q == REQ_INIT) ? start_phase(next_init.kind) : PH_HI_HIGH;
			end else begin
				ph_q <= ph_q + 1'b1;
			end
		end
	end

	always_comb begin
		dig_ctrl.load = (state_q == ST_IDLE) && accept && (req_type == REQ_NUM) && (cnt != '0);
		dig_ctrl.pop = (state_q == ST_EMIT) && (req_q == REQ_NUM) && unit_end;
		dig_ctrl.value = number_value;
		dig_ctrl.count = cnt;
	end

	clwseq_digits #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_digits (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(dig_ctrl),
		.stat(dig_stat)
	);

	assign strobe = (state_q == ST_EMIT);
	assign enable_pin = (ph_q == PH_HI_HIGH) || (ph_q == PH_LO_HIGH);
	assign register_select = cur_rs;
	assign last_state = req_end;

	always_comb begin
		if (ph_q == PH_HI_HIGH || ph_q == PH_HI_LOW) begin
			data_nibble = cur.value[7:4];
		end else if (ph_q == PH_LO_HIGH || ph_q == PH_LO_LOW) begin
			data_nibble = cur.value[3:0];
		end else begin
			data_nibble = 4'd0;
		end
	end

	always_comb begin
		hold_us = STROBE_US;
		if (ph_q == PH_SETTLE) begin
			unique case (cur.hold)
				HOLD_POWER: hold_us = POWER_WAIT_US;
				HOLD_WAIT1: hold_us = INIT_WAIT1_US;
				HOLD_WAIT2: hold_us = INIT_WAIT2_US;
				HOLD_WAIT3: hold_us = INIT_WAIT3_US;
				HOLD_WAIT4: hold_us = INIT_WAIT4_US;
				HOLD_SETTLE: hold_us = {8'd0, settle_q};
				HOLD_CLEAR: hold_us = {2'd0, clear_q};
				default: hold_us = STROBE_US;
			endcase
		end
	end

	`ASSERT_HOLDS(a_last_then_idle, clk, arst_n, strobe && last_state |=> !strobe && !busy, "request did not end after its last state")
	`ASSERT_HOLDS(a_init_emits, clk, arst_n, accept && (req_type == REQ_INIT) |=> strobe, "initialise request did not start emitting")
	`ASSERT_HOLDS(a_strobe_hold, clk, arst_n, strobe && enable_pin |-> (hold_us == STROBE_US), "enable pulse with wrong hold")
	`ASSERT_NEVER(a_emit_while_digits, clk, arst_n, strobe && dig_stat.busy, "pin state shown while digits are still found")

endmodule
